### hdl/ascon_aead128_engine_unit_macros.svh
// ------------------------------------------------------------------------
// Assertion macros for the Ascon-AEAD128 engine
// Shared concurrent checks, clocked on the rising edge.
// ------------------------------------------------------------------------
`ifndef ASCON_AEAD128_ENGINE_UNIT_MACROS_SVH
`define ASCON_AEAD128_ENGINE_UNIT_MACROS_SVH

// implication checked outside reset
`define ASC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ascon engine check failed");

// condition that must hold in the cycle after reset was high
`define ASC_ASSERT_AFTER_RESET(lbl, clk, rst, cons) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("ascon engine reset check failed");

`endif

### hdl/ascon_pkg.sv
// ------------------------------------------------------------------------
// ascon_pkg
// Types, constants and the permutation round for the Ascon-AEAD128 engine.
// ------------------------------------------------------------------------
`default_nettype none

package ascon_pkg;

   localparam int WORD_W  = 64;
   localparam int BLOCK_W = 128;
   localparam int LEN_W   = 5;
   localparam int LANES   = 5;

   localparam logic [LEN_W-1:0] FULL_LEN = 5'd16;

   localparam logic [WORD_W-1:0] ASCON_IV = 64'h00001000808c0001;
   localparam logic [WORD_W-1:0] DOM_SEP  = 64'h8000000000000000;

   localparam logic [1:0] CSR_KEY_LOW  = 2'd0;
   localparam logic [1:0] CSR_KEY_HIGH = 2'd1;
   localparam logic [1:0] CSR_DECRYPT  = 2'd2;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_AD    = 2'd1,
      OP_TEXT  = 2'd2,
      OP_FINAL = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_TEXT   = 2'd0,
      KIND_TAG    = 2'd1,
      KIND_VERIFY = 2'd2
   } result_kind_type;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [WORD_W-1:0] word_low;
      logic [WORD_W-1:0] word_high;
      logic [LEN_W-1:0]  byte_count;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] out_word_low;
      logic [WORD_W-1:0] out_word_high;
      logic [LEN_W-1:0]  out_byte_count;
      logic [1:0]        result_kind;
      logic              tag_ok;
      logic              order_error;
   } rsp_type;

   // decoded request as it sits in the queue
   typedef struct packed {
      opcode_type         op;
      logic [BLOCK_W-1:0] block;
      logic [BLOCK_W-1:0] mask;
      logic [LEN_W-1:0]   len;
      logic               full;
   } cmd_type;

   typedef logic [LANES-1:0][WORD_W-1:0] lanes_type;

   function automatic logic [7:0] round_const(input logic [3:0] idx);
      logic [7:0] rc;
      case (idx)
         4'd0:    rc = 8'h3c;
         4'd1:    rc = 8'h2d;
         4'd2:    rc = 8'h1e;
         4'd3:    rc = 8'h0f;
         4'd4:    rc = 8'hf0;
         4'd5:    rc = 8'he1;
         4'd6:    rc = 8'hd2;
         4'd7:    rc = 8'hc3;
         4'd8:    rc = 8'hb4;
         4'd9:    rc = 8'ha5;
         4'd10:   rc = 8'h96;
         4'd11:   rc = 8'h87;
         4'd12:   rc = 8'h78;
         4'd13:   rc = 8'h69;
         4'd14:   rc = 8'h5a;
         4'd15:   rc = 8'h4b;
         default: rc = 8'h00;
      endcase
      return rc;
   endfunction

   function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v, input int n);
      return (v >> n) | (v << (WORD_W - n));
   endfunction

   // one round: constant addition, S-box layer, linear diffusion
   function automatic lanes_type ascon_round(input lanes_type s, input logic [7:0] rc);
      lanes_type x;
      lanes_type t;
      lanes_type r;
      x    = s;
      x[2] = x[2] ^ {56'h0, rc};
      x[0] = x[0] ^ x[4];
      x[4] = x[4] ^ x[3];
      x[2] = x[2] ^ x[1];
      t[0] = x[0] ^ (~x[1] & x[2]);
      t[1] = x[1] ^ (~x[2] & x[3]);
      t[2] = x[2] ^ (~x[3] & x[4]);
      t[3] = x[3] ^ (~x[4] & x[0]);
      t[4] = x[4] ^ (~x[0] & x[1]);
      t[1] = t[1] ^ t[0];
      t[0] = t[0] ^ t[4];
      t[3] = t[3] ^ t[2];
      t[2] = ~t[2];
      r[0] = t[0] ^ rotr(t[0], 19) ^ rotr(t[0], 28);
      r[1] = t[1] ^ rotr(t[1], 61) ^ rotr(t[1], 39);
      r[2] = t[2] ^ rotr(t[2], 1) ^ rotr(t[2], 6);
      r[3] = t[3] ^ rotr(t[3], 10) ^ rotr(t[3], 17);
      r[4] = t[4] ^ rotr(t[4], 7) ^ rotr(t[4], 41);
      return r;
   endfunction

endpackage

`default_nettype wire

### hdl/ascon_front.sv
// ------------------------------------------------------------------------
// ascon_front
// Accepts requests, clamps the byte count, builds the byte mask and
// holds decoded requests in a short queue for the sequencer.
// ------------------------------------------------------------------------
`default_nettype none

module ascon_front #(
   parameter int DEPTH = 2
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  ascon_pkg::req_type      req_data,
   output logic                    cmd_valid,
   output ascon_pkg::cmd_type      cmd_data,
   input  wire                     cmd_pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ascon_pkg::cmd_type     entry_ff [DEPTH];
   ascon_pkg::cmd_type     decoded;
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [ascon_pkg::LEN_W-1:0] len_clamped;
   logic                   push;
   logic                   pop;

   always_comb begin
      len_clamped = (req_data.byte_count > ascon_pkg::FULL_LEN) ?
                    ascon_pkg::FULL_LEN : req_data.byte_count;
      decoded.op    = ascon_pkg::opcode_type'(req_data.opcode);
      decoded.block = {req_data.word_high, req_data.word_low};
      decoded.len   = len_clamped;
      decoded.full  = (len_clamped == ascon_pkg::FULL_LEN);
      for (int k = 0; k < ascon_pkg::BLOCK_W / 8; k++) begin
         decoded.mask[8*k +: 8] = (ascon_pkg::LEN_W'(k) < len_clamped) ? 8'hff : 8'h00;
      end
   end

   assign req_stall = (count_ff == CNT_W'(DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != '0);
   assign pop       = cmd_pop && cmd_valid;
   assign cmd_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

### hdl/ascon_back.sv
// ------------------------------------------------------------------------
// ascon_back
// Sequencer that carries out queued requests on the 320-bit state,
// one permutation round per cycle, and drives the response register.
// ------------------------------------------------------------------------
`default_nettype none

module ascon_back (
   input  wire                          clock,
   input  wire                          reset,
   input  wire [ascon_pkg::WORD_W-1:0]  key_low,
   input  wire [ascon_pkg::WORD_W-1:0]  key_high,
   input  wire                          decrypt_mode,
   input  wire                          cmd_valid,
   input  ascon_pkg::cmd_type           cmd_data,
   output logic                         cmd_pop,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output ascon_pkg::rsp_type           rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_ROUND,
      ST_POST,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_AD_OPEN,
      PH_AD_BUSY,
      PH_TEXT,
      PH_TEXT_DONE
   } phase_type;

   typedef enum logic [2:0] {
      PO_START,
      PO_AD,
      PO_CLOSE,
      PO_TEXT,
      PO_FINAL
   } post_type;

   state_type             state_ff, state_in;
   phase_type             phase_ff, phase_in;
   post_type              post_ff, post_in;
   ascon_pkg::lanes_type  lanes_ff, lanes_in;
   logic [3:0]            rc_ff, rc_in;
   ascon_pkg::cmd_type    cmd_ff, cmd_in;
   ascon_pkg::rsp_type    res_ff, res_in;
   ascon_pkg::rsp_type    rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [ascon_pkg::BLOCK_W-1:0] rate_cur;
   logic [ascon_pkg::BLOCK_W-1:0] rate_new;
   logic [ascon_pkg::BLOCK_W-1:0] text_out;
   logic [ascon_pkg::BLOCK_W-1:0] pad_vec;
   logic [ascon_pkg::BLOCK_W-1:0] tag_vec;
   logic                          order_err;

   assign cmd_pop   = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      post_in      = post_ff;
      lanes_in     = lanes_ff;
      rc_in        = rc_ff;
      cmd_in       = cmd_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      order_err    = 1'b0;

      rate_cur = {lanes_ff[1], lanes_ff[0]};
      pad_vec  = ascon_pkg::BLOCK_W'(1) << {cmd_ff.len[3:0], 3'b000};
      tag_vec  = {lanes_ff[4] ^ key_high, lanes_ff[3] ^ key_low};
      if (decrypt_mode) begin
         text_out = (rate_cur ^ cmd_ff.block) & cmd_ff.mask;
         rate_new = (rate_cur & ~cmd_ff.mask) | (cmd_ff.block & cmd_ff.mask);
      end else begin
         rate_new = rate_cur ^ (cmd_ff.block & cmd_ff.mask);
         text_out = rate_new & cmd_ff.mask;
      end

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_in   = cmd_data;
               state_in = ST_DISPATCH;
            end
         end

         ST_DISPATCH: begin
            case (cmd_ff.op)
               ascon_pkg::OP_START: begin
                  if (phase_ff != PH_IDLE) begin
                     order_err = 1'b1;
                  end else begin
                     lanes_in[0] = ascon_pkg::ASCON_IV;
                     lanes_in[1] = key_low;
                     lanes_in[2] = key_high;
                     lanes_in[3] = cmd_ff.block[63:0];
                     lanes_in[4] = cmd_ff.block[127:64];
                     rc_in       = 4'd4;
                     post_in     = PO_START;
                     state_in    = ST_ROUND;
                  end
               end

               ascon_pkg::OP_AD: begin
                  if (phase_ff == PH_AD_OPEN || phase_ff == PH_AD_BUSY) begin
                     {lanes_in[1], lanes_in[0]} = rate_cur ^ (cmd_ff.block & cmd_ff.mask) ^
                                                  (cmd_ff.full ? '0 : pad_vec);
                     rc_in    = 4'd8;
                     post_in  = PO_AD;
                     state_in = ST_ROUND;
                  end else begin
                     order_err = 1'b1;
                  end
               end

               ascon_pkg::OP_TEXT: begin
                  if (phase_ff == PH_IDLE || phase_ff == PH_TEXT_DONE) begin
                     order_err = 1'b1;
                  end else if (phase_ff == PH_AD_BUSY) begin
                     // close associated data with an empty padded block
                     lanes_in[0] = lanes_ff[0] ^ 64'h1;
                     rc_in       = 4'd8;
                     post_in     = PO_CLOSE;
                     state_in    = ST_ROUND;
                  end else if (phase_ff == PH_AD_OPEN) begin
                     lanes_in[4] = lanes_ff[4] ^ ascon_pkg::DOM_SEP;
                     phase_in    = PH_TEXT;
                  end else begin
                     res_in                = '0;
                     res_in.out_word_low   = text_out[63:0];
                     res_in.out_word_high  = text_out[127:64];
                     res_in.out_byte_count = cmd_ff.len;
                     res_in.result_kind    = ascon_pkg::KIND_TEXT;
                     if (cmd_ff.full) begin
                        {lanes_in[1], lanes_in[0]} = rate_new;
                        rc_in    = 4'd8;
                        post_in  = PO_TEXT;
                        state_in = ST_ROUND;
                     end else begin
                        {lanes_in[1], lanes_in[0]} = rate_new ^ pad_vec;
                        phase_in = PH_TEXT_DONE;
                        state_in = ST_EMIT;
                     end
                  end
               end

               ascon_pkg::OP_FINAL: begin
                  if (phase_ff == PH_IDLE) begin
                     order_err = 1'b1;
                  end else if (phase_ff == PH_AD_BUSY) begin
                     lanes_in[0] = lanes_ff[0] ^ 64'h1;
                     rc_in       = 4'd8;
                     post_in     = PO_CLOSE;
                     state_in    = ST_ROUND;
                  end else if (phase_ff == PH_AD_OPEN) begin
                     lanes_in[4] = lanes_ff[4] ^ ascon_pkg::DOM_SEP;
                     phase_in    = PH_TEXT;
                  end else begin
                     // an open text phase still owes its empty padded block
                     if (phase_ff == PH_TEXT) begin
                        lanes_in[0] = lanes_ff[0] ^ 64'h1;
                     end
                     lanes_in[2] = lanes_ff[2] ^ key_low;
                     lanes_in[3] = lanes_ff[3] ^ key_high;
                     rc_in       = 4'd4;
                     post_in     = PO_FINAL;
                     state_in    = ST_ROUND;
                  end
               end

               default: begin
                  order_err = 1'b1;
               end
            endcase

            if (order_err) begin
               res_in             = '0;
               res_in.order_error = 1'b1;
               state_in           = ST_EMIT;
            end
         end

         ST_ROUND: begin
            lanes_in = ascon_pkg::ascon_round(lanes_ff, ascon_pkg::round_const(rc_ff));
            rc_in    = 4'(rc_ff + 4'd1);
            if (rc_ff == 4'hf) begin
               state_in = ST_POST;
            end
         end

         ST_POST: begin
            case (post_ff)
               PO_START: begin
                  lanes_in[3] = lanes_ff[3] ^ key_low;
                  lanes_in[4] = lanes_ff[4] ^ key_high;
                  phase_in    = PH_AD_OPEN;
                  state_in    = ST_IDLE;
               end
               PO_AD: begin
                  if (cmd_ff.full) begin
                     phase_in = PH_AD_BUSY;
                  end else begin
                     lanes_in[4] = lanes_ff[4] ^ ascon_pkg::DOM_SEP;
                     phase_in    = PH_TEXT;
                  end
                  state_in = ST_IDLE;
               end
               PO_CLOSE: begin
                  // resume the pending text or finalize request
                  lanes_in[4] = lanes_ff[4] ^ ascon_pkg::DOM_SEP;
                  phase_in    = PH_TEXT;
                  state_in    = ST_DISPATCH;
               end
               PO_TEXT: begin
                  state_in = ST_EMIT;
               end
               PO_FINAL: begin
                  res_in = '0;
                  if (decrypt_mode) begin
                     res_in.result_kind = ascon_pkg::KIND_VERIFY;
                     res_in.tag_ok      = (tag_vec == cmd_ff.block);
                  end else begin
                     res_in.result_kind   = ascon_pkg::KIND_TAG;
                     res_in.out_word_low  = tag_vec[63:0];
                     res_in.out_word_high = tag_vec[127:64];
                  end
                  phase_in = PH_IDLE;
                  state_in = ST_EMIT;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_EMIT: begin
            // hold until the response register frees up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      lanes_ff <= lanes_in;
      rc_ff    <= rc_in;
      cmd_ff   <= cmd_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
      post_ff  <= post_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### hdl/ascon_aead128_engine_unit.sv
// Path from acceptance to response valid: queue, idle, dispatch, emit for a short final
// text block or an order error; full text blocks and finalize also run the permutation
// rounds, one per cycle, then post. An open associated phase adds a dispatch pass, and
// owed padding a closing round run; associated data and start return to idle after post.
// Throughput: one request at a time; the queue keeps accepting while one runs.
// Synchronous reset empties queue and response register, returns the phase to idle.
// ------------------------------------------------------------------------
// ascon_aead128_engine_unit
// Ascon-AEAD128 engine: configuration registers, request front end,
// round sequencer and response register.
// ------------------------------------------------------------------------
`default_nettype none
`include "ascon_aead128_engine_unit_macros.svh"

module ascon_aead128_engine_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  ascon_pkg::req_type           req_data,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output ascon_pkg::rsp_type           rsp_data,
   input  wire                          csr_write_enable,
   input  wire [1:0]                    csr_index,
   input  wire [ascon_pkg::WORD_W-1:0]  csr_write_data
);

   logic [ascon_pkg::WORD_W-1:0] key_low_ff, key_high_ff;
   logic                         decrypt_mode_ff;
   logic                         cmd_valid;
   logic                         cmd_pop;
   ascon_pkg::cmd_type           cmd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff      <= '0;
         key_high_ff     <= '0;
         decrypt_mode_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            ascon_pkg::CSR_KEY_LOW:  key_low_ff      <= csr_write_data;
            ascon_pkg::CSR_KEY_HIGH: key_high_ff     <= csr_write_data;
            ascon_pkg::CSR_DECRYPT:  decrypt_mode_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   ascon_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop)
   );

   ascon_back u_back (
      .clock        (clock),
      .reset        (reset),
      .key_low      (key_low_ff),
      .key_high     (key_high_ff),
      .decrypt_mode (decrypt_mode_ff),
      .cmd_valid    (cmd_valid),
      .cmd_data     (cmd_data),
      .cmd_pop      (cmd_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

   `ASC_ASSERT_AFTER_RESET(a_reset_clears, clock, reset, !rsp_valid && !req_stall)
   `ASC_ASSERT_IMPLY(a_error_clean, clock, reset, rsp_valid && rsp_data.order_error, rsp_data.result_kind == ascon_pkg::KIND_TEXT && rsp_data.out_byte_count == '0 && !rsp_data.tag_ok && rsp_data.out_word_low == '0 && rsp_data.out_word_high == '0)
   `ASC_ASSERT_IMPLY(a_tag_clean, clock, reset, rsp_valid && rsp_data.result_kind == ascon_pkg::KIND_TAG, rsp_data.out_byte_count == '0 && !rsp_data.tag_ok && !rsp_data.order_error)
   `ASC_ASSERT_IMPLY(a_text_len, clock, reset, rsp_valid && rsp_data.result_kind == ascon_pkg::KIND_TEXT, rsp_data.out_byte_count <= ascon_pkg::FULL_LEN && !rsp_data.tag_ok)

endmodule

`default_nettype wire
